### rtl/dmh_pkg.sv
// package for the double hash unit: widths and special codes
`default_nettype none
package dmh_pkg;

  localparam int unsigned ModulusBitsDefault = 61;
  localparam int unsigned ValueWidth  = 64;
  localparam int unsigned HashWidth   = 62;
  localparam int unsigned InDataWidth = 64;
  localparam int unsigned OutDataWidth = 64;
  localparam int unsigned ExpWidth    = 11;
  localparam int unsigned FracWidth   = 52;
  localparam int unsigned SigWidth    = 53;
  localparam logic [ExpWidth-1:0] ExpSpecial = '1;
  localparam logic [HashWidth-1:0] InfHash = HashWidth'(314159);

endpackage
`default_nettype wire

### rtl/dmh_core.sv
// combinational hash of one binary64 pattern modulo 2^MB-1
`default_nettype none
module dmh_core #(
  parameter int unsigned ModulusBits = dmh_pkg::ModulusBitsDefault
) (
  input  wire logic [dmh_pkg::ValueWidth-1:0] value_bits_i,
  output logic      [dmh_pkg::HashWidth-1:0]  hash_value_o
);
  localparam int unsigned MB = ModulusBits;
  localparam int unsigned HW = dmh_pkg::HashWidth;
  localparam int unsigned EW = 12;  // signed biased exponent span
  localparam int unsigned RW = $clog2(MB);
  localparam logic [MB-1:0] P = '1;
  // reciprocal of MB scaled by 2^RecipShift, rounded up; exact quotient for eoff below 2048
  localparam int unsigned RecipShift = 22;
  localparam int unsigned PW = EW + RecipShift;
  localparam int unsigned RecipMul = ((1 << RecipShift) + MB - 1) / MB;

  logic                           neg;
  logic [dmh_pkg::ExpWidth-1:0]   bexp;
  logic [dmh_pkg::FracWidth-1:0]  frac;
  logic [dmh_pkg::SigWidth-1:0]   sig;
  logic [EW-1:0]                  eoff;   // exponent + 1075, 1..2046 for finite values
  logic [PW-1:0]                  eoff_prod;
  logic [EW-1:0]                  eoff_quot;
  logic [EW-1:0]                  eoff_mod;
  logic [RW-1:0]                  rot;
  logic [MB+1:0]                  f1;
  logic [MB:0]                    f2;
  logic [MB-1:0]                  res, rotd;
  logic [2*MB-1:0]                dbl;
  logic [HW-1:0]                  mag;

  localparam logic [EW-1:0] BiasOff = EW'((1075 % MB));

  always_comb begin
    neg  = value_bits_i[dmh_pkg::ValueWidth-1];
    bexp = value_bits_i[dmh_pkg::ValueWidth-2 -: dmh_pkg::ExpWidth];
    frac = value_bits_i[dmh_pkg::FracWidth-1:0];
    sig  = {(bexp != '0), frac};
    eoff = (bexp == '0) ? EW'(1) : EW'(bexp);
    // significand fold: two passes suffice for 53 bits
    f1 = (MB+2)'(sig & (dmh_pkg::SigWidth)'(P)) + (MB+2)'(sig >> MB);
    f2 = (MB+1)'(f1 & (MB+2)'(P)) + (MB+1)'(f1 >> MB);
    res = (f2 >= (MB+1)'(P)) ? MB'(f2 - (MB+1)'(P)) : MB'(f2);
    // (e mod MB) = (eoff - 1075) mod MB, eoff below 2048, by reciprocal multiply
    eoff_prod = PW'(eoff) * PW'(RecipMul);
    eoff_quot = EW'(eoff_prod >> RecipShift);
    eoff_mod  = eoff - eoff_quot * EW'(MB);
    rot = (eoff_mod >= BiasOff) ? RW'(eoff_mod - BiasOff)
                                : RW'(eoff_mod + EW'(MB) - BiasOff);
    dbl  = {res, res} << rot;
    rotd = dbl[2*MB-1 -: MB];
    if (neg && rotd == MB'(1)) mag = HW'(2);
    else mag = HW'(rotd);
    if (bexp == dmh_pkg::ExpSpecial) begin
      if (frac != '0) hash_value_o = '0;
      else hash_value_o = neg ? -dmh_pkg::InfHash : dmh_pkg::InfHash;
    end else begin
      hash_value_o = neg ? -mag : mag;
    end
  end
endmodule
`default_nettype wire

### rtl/double_mersenne_hash_unit.sv
// top level of the double hash unit: input register, hash logic, output register
//
//  channel   | dir | tdata bits
//  s_axis    | in  | [63:0] value_bits
//  m_axis    | out | [61:0] hash_value, [63:62] zero
//
// one beat per cycle sustained while m_axis_tready stays high; each beat is
// registered in the input stage, hashed, then registered in the output stage
// input stage and output stage each hold one beat; the input takes a beat
// whenever the input stage is empty or moves on in the same cycle
// reset empties both stages; payload registers are not reset
`default_nettype none
module double_mersenne_hash_unit #(
  parameter int unsigned ModulusBits = dmh_pkg::ModulusBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [63:0] value_bits
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata    // [61:0] hash_value, rest zero
);
  logic                           in_vld_q, out_vld_q;
  logic [dmh_pkg::ValueWidth-1:0] in_q;
  logic [dmh_pkg::HashWidth-1:0]  out_q, hash_d;
  logic                           out_take, in_take;

  dmh_core #(.ModulusBits(ModulusBits)) u_core (
    .value_bits_i(in_q),
    .hash_value_o(hash_d)
  );

  // stage advance
  assign out_take      = !out_vld_q || m_axis_tready;
  assign in_take       = !in_vld_q || out_take;
  assign s_axis_tready = in_take;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_q};

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_take) out_vld_q <= in_vld_q;
      if (in_take) in_vld_q <= s_axis_tvalid;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_take && s_axis_tvalid) in_q <= s_axis_tdata;
    if (out_take && in_vld_q) out_q <= hash_d;
  end
endmodule
`default_nettype wire

### verif/dmh_checker.sv
// checker for the double hash unit: predicts each hash and compares result beats
`default_nettype none
module dmh_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [63:0] m_axis_tdata,
  output int               fail_count_o,
  output int               pending_o
);
  localparam logic [63:0] Prime = (64'd1 << dmh_pkg::ModulusBitsDefault) - 64'd1;

  logic [dmh_pkg::HashWidth-1:0] hash_queue[$];

  // residue of a value below 2^63 modulo the mersenne prime
  function automatic logic [63:0] mersenne_reduce(input logic [63:0] v);
    logic [63:0] acc;
    acc = v;
    while (acc > Prime) acc = (acc & Prime) + (acc >> dmh_pkg::ModulusBitsDefault);
    if (acc == Prime) acc = '0;
    return acc;
  endfunction

  // hash of one binary64 pattern
  function automatic logic [dmh_pkg::HashWidth-1:0] double_hash(input logic [63:0] bits);
    logic            sign;
    logic [10:0]     biased;
    logic [51:0]     frac;
    logic [63:0]     sig;
    logic [63:0]     acc;
    logic [63:0]     signed_res;
    int              expo;
    int              rot;
    sign   = bits[63];
    biased = bits[62:52];
    frac   = bits[51:0];
    if (biased == dmh_pkg::ExpSpecial) begin
      if (frac != '0) return '0;
      return sign ? dmh_pkg::HashWidth'(-64'sd314159) : dmh_pkg::InfHash;
    end
    if (biased == '0) begin
      sig  = {12'd0, frac};
      expo = -1074;
    end else begin
      sig  = {11'd0, 1'b1, frac};
      expo = int'(biased) - 1075;
    end
    acc = mersenne_reduce(sig);
    rot = expo % int'(dmh_pkg::ModulusBitsDefault);
    if (rot < 0) rot += dmh_pkg::ModulusBitsDefault;
    if (rot != 0)
      acc = ((acc << rot) & Prime) | (acc >> (dmh_pkg::ModulusBitsDefault - rot));
    if (sign) begin
      if (acc == 64'd1) acc = 64'd2;
      signed_res = 64'd0 - acc;
    end else begin
      signed_res = acc;
    end
    return signed_res[dmh_pkg::HashWidth-1:0];
  endfunction

  assign pending_o = hash_queue.size();

  // predict on input beats, compare on output beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) hash_queue.push_back(double_hash(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (hash_queue.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %h", $time, m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          if (m_axis_tdata !== {2'b00, hash_queue[0]}) begin
            $display("%0t: hash mismatch, expected %h, actual %h", $time,
                     {2'b00, hash_queue[0]}, m_axis_tdata);
            fail_count_o <= fail_count_o + 1;
          end
          void'(hash_queue.pop_front());
        end
      end
    end
  end
endmodule
`default_nettype wire

### verif/tb_double_mersenne_hash_unit.sv
// testbench top for the double hash unit: stimulus, idling phases and verdict
`default_nettype none
module tb_double_mersenne_hash_unit;
  localparam int CycleLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tready = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [63:0] m_axis_tdata;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  always #5 clk_i = ~clk_i;

  double_mersenne_hash_unit u_top (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  dmh_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stalls at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // one beat, with random idle cycles before it
  task automatic send_value(input logic [63:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // random double pattern biased toward interesting classes
  function automatic logic [63:0] random_double();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0: v[62:52] = 11'h7ff;
      1: v[62:52] = 11'h000;
      2: v[51:0]  = 52'd0;
      3: v[62:52] = 11'h3ff + 11'($urandom_range(120)) - 11'd60;
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [63:0] directed[$];
    directed = '{64'h0, 64'h8000_0000_0000_0000, 64'h7ff0_0000_0000_0000,
                 64'hfff0_0000_0000_0000, 64'h7ff8_0000_0000_0000,
                 64'hffff_ffff_ffff_ffff, 64'h7ff0_0000_0000_0001,
                 64'h0000_0000_0000_0001, 64'h800f_ffff_ffff_ffff,
                 64'h0010_0000_0000_0000, 64'h3ff0_0000_0000_0000,
                 64'hbff0_0000_0000_0000, 64'h7fef_ffff_ffff_ffff,
                 64'hffef_ffff_ffff_ffff, 64'h4000_0000_0000_0000,
                 64'h43c0_0000_0000_0000, 64'hc3c0_0000_0000_0000,
                 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
                 64'h3cb0_0000_0000_0000, 64'hbcb0_0000_0000_0000};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_value(directed[i]);
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 60 : 34) : 0;
      stall_pct     = (phase == 2 || phase == 3) ? (phase == 2 ? 60 : 34) : 0;
      repeat (235) send_value(random_double());
    end
    s_axis_tvalid <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
